// ----- hdl/srht_pkg.sv -----
// Shared types and constants for the search result hash table.
package srht_pkg;

  localparam int INDEX_BITS_DEFAULT = 10;

  localparam int KEY_W   = 64;
  localparam int DEPTH_W = 7;
  localparam int SDEPTH_W = 8;
  localparam int SCORE_W = 25;
  localparam int BOUND_W = 2;
  localparam int MOVE_W  = 16;
  localparam int EVAL_W  = 24;
  localparam int KIND_W  = 2;

  localparam logic [KIND_W-1:0] KIND_PROBE       = 2'd0;
  localparam logic [KIND_W-1:0] KIND_STORE_RESULT = 2'd1;
  localparam logic [KIND_W-1:0] KIND_STORE_EVAL  = 2'd2;

  localparam logic [BOUND_W-1:0] BOUND_EXACT = 2'd0;
  localparam logic [BOUND_W-1:0] BOUND_UPPER = 2'd2;
  localparam logic [BOUND_W-1:0] BOUND_BAD   = 2'd3;

  localparam logic signed [SCORE_W-1:0] SCORE_MAX = 25'sd10000000;
  localparam logic signed [SCORE_W-1:0] SCORE_MIN = -25'sd10000000;

  localparam logic signed [SDEPTH_W-1:0] EMPTY_DEPTH = -8'sd1;

  typedef struct packed {
    logic [KIND_W-1:0]         kind;
    logic [KEY_W-1:0]          key;
    logic [DEPTH_W-1:0]        depth;
    logic signed [SCORE_W-1:0] score;
    logic [BOUND_W-1:0]        bound;
    logic [MOVE_W-1:0]         best_move;
    logic signed [EVAL_W-1:0]  pos_eval;
  } req_t;

  typedef struct packed {
    logic [KEY_W-1:0]           key;
    logic signed [SDEPTH_W-1:0] depth;
    logic signed [SCORE_W-1:0]  score;
    logic [BOUND_W-1:0]         bound;
    logic [MOVE_W-1:0]          best_move;
    logic signed [EVAL_W-1:0]   eval;
    logic                       eval_valid;
  } entry_t;

  localparam entry_t ENTRY_EMPTY = '{
    key: '0, depth: EMPTY_DEPTH, score: '0, bound: BOUND_EXACT,
    best_move: '0, eval: '0, eval_valid: 1'b0
  };

endpackage

// ----- hdl/srht_update.sv -----
// Slot update rules: hit test, replacement decision and new slot contents.
module srht_update (
  input  srht_pkg::req_t   req,
  input  srht_pkg::entry_t old,
  output logic             found,
  output logic             written,
  output srht_pkg::entry_t upd
);
  import srht_pkg::*;

  logic signed [SCORE_W-1:0] score_sat;
  logic [BOUND_W-1:0]        bound_sat;
  logic                      deeper;
  entry_t                    res_entry;
  entry_t                    eval_entry;

  always_comb begin
    if (req.score > SCORE_MAX) begin
      score_sat = SCORE_MAX;
    end else if (req.score < SCORE_MIN) begin
      score_sat = SCORE_MIN;
    end else begin
      score_sat = req.score;
    end
    bound_sat = (req.bound == BOUND_BAD) ? BOUND_UPPER : req.bound;
  end

  assign found  = (old.key == req.key);
  assign deeper = (old.depth < $signed({1'b0, req.depth}));

  always_comb begin
    res_entry            = old;
    res_entry.key        = req.key;
    res_entry.depth      = $signed({1'b0, req.depth});
    res_entry.score      = score_sat;
    res_entry.bound      = bound_sat;
    res_entry.best_move  = req.best_move;
    // a new key drops the cached evaluation
    if (!found) begin
      res_entry.eval       = '0;
      res_entry.eval_valid = 1'b0;
    end

    eval_entry            = old;
    eval_entry.key        = req.key;
    eval_entry.eval       = req.pos_eval;
    eval_entry.eval_valid = 1'b1;
  end

  always_comb begin
    written = 1'b0;
    upd     = old;
    case (req.kind)
      KIND_STORE_RESULT: begin
        if (!found || deeper) begin
          written = 1'b1;
          upd     = res_entry;
        end
      end
      KIND_STORE_EVAL: begin
        // negative depth marks an empty slot
        if (old.depth[SDEPTH_W-1] || found) begin
          written = 1'b1;
          upd     = eval_entry;
        end
      end
      default: begin
        written = 1'b0;
        upd     = old;
      end
    endcase
  end

endmodule

// ----- hdl/search_result_hash_table.sv -----
// Direct-mapped search result hash table, top level.
//
// One request is one read-modify-write of the slot picked by the low INDEX_BITS
// bits of the key. The slots live in a single synchronous memory with registered
// read data: the slot is read when the request is taken, then updated and written
// back once the output register is free, and the result lands in that register.
// A new request is taken only after the last one has been written back; a pending
// result does not block the next read, only its write-back. After reset the memory
// is cleared one slot per cycle, during which s_tready stays low. A zero key
// matches a never-written slot, so check found_depth (-1 = empty) as well as
// found.
module search_result_hash_table #(
  parameter int INDEX_BITS = srht_pkg::INDEX_BITS_DEFAULT
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  // key[63:0], depth[70:64], score[95:71], bound[97:96], best_move[113:98],
  // pos_eval[137:114], zero fill above
  input  logic [143:0] s_tdata,
  // kind[1:0]
  input  logic [1:0]   s_tuser,
  output logic         m_tvalid,
  input  logic         m_tready,
  // found[0], written[1], found_depth[9:2], found_score[34:10],
  // found_bound[36:35], found_move[52:37], found_eval[76:53],
  // found_eval_valid[77], zero fill above
  output logic [79:0]  m_tdata
);
  import srht_pkg::*;

  localparam int SLOTS = 1 << INDEX_BITS;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_LOOKUP
  } state_t;

  state_t                state;
  logic [INDEX_BITS-1:0] clr_idx;
  logic [INDEX_BITS-1:0] idx;
  req_t                  req;
  req_t                  req_in;
  entry_t                mem [SLOTS];
  entry_t                rdata;
  entry_t                upd;
  logic                  found;
  logic                  written;
  logic                  take;
  logic                  commit;
  logic                  mem_we;
  logic [INDEX_BITS-1:0] mem_waddr;
  entry_t                mem_wdata;

  assign req_in.kind        = s_tuser;
  assign req_in.key         = s_tdata[63:0];
  assign req_in.depth       = s_tdata[70:64];
  assign req_in.score       = s_tdata[95:71];
  assign req_in.bound       = s_tdata[97:96];
  assign req_in.best_move   = s_tdata[113:98];
  assign req_in.pos_eval    = s_tdata[137:114];

  assign s_tready = (state == ST_IDLE);
  assign take     = s_tvalid && s_tready;
  assign commit   = (state == ST_LOOKUP) && (!m_tvalid || m_tready);
  assign idx      = req.key[INDEX_BITS-1:0];

  srht_update u_update (
    .req     (req),
    .old     (rdata),
    .found   (found),
    .written (written),
    .upd     (upd)
  );

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = idx;
    mem_wdata = upd;
    if (state == ST_CLEAR) begin
      mem_we    = 1'b1;
      mem_waddr = clr_idx;
      mem_wdata = ENTRY_EMPTY;
    end else if (commit && written) begin
      mem_we = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
  end

  // read data holds until the next request, so a stalled lookup stays valid
  always_ff @(posedge clk) begin
    if (take) begin
      rdata <= mem[req_in.key[INDEX_BITS-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      req <= req_in;
    end
    if (commit) begin
      m_tdata <= {2'b00, upd.eval_valid, upd.eval, upd.best_move, upd.bound,
                  upd.score, upd.depth, written, found};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_CLEAR;
      clr_idx  <= '0;
      m_tvalid <= 1'b0;
    end else begin
      if (commit) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        ST_CLEAR: begin
          clr_idx <= clr_idx + 1'b1;
          if (clr_idx == INDEX_BITS'(SLOTS - 1)) begin
            state <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (take) begin
            state <= ST_LOOKUP;
          end
        end
        ST_LOOKUP: begin
          if (commit) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_CLEAR;
        end
      endcase
    end
  end

endmodule

// ----- tb/search_result_hash_table_tb.sv -----
// Testbench for the search result hash table: directed and random requests
// checked against a slot-level model of the table.
`timescale 1ns / 100ps

module search_result_hash_table_tb;
  import srht_pkg::*;

  localparam int INDEX_BITS = INDEX_BITS_DEFAULT;
  localparam int SLOTS = 1 << INDEX_BITS;
  localparam logic [KIND_W-1:0] KIND_RESERVED = 2'd3;
  localparam logic [BOUND_W-1:0] BOUND_LOWER = 2'd1;
  localparam int HOLD_CYCLES = 300;
  localparam int CYCLE_LIMIT = 300000;

  typedef struct packed {
    logic                       found;
    logic                       written;
    logic signed [SDEPTH_W-1:0] depth;
    logic signed [SCORE_W-1:0]  score;
    logic [BOUND_W-1:0]         bound;
    logic [MOVE_W-1:0]          best_move;
    logic signed [EVAL_W-1:0]   eval;
    logic                       eval_valid;
  } reply_t;

  logic         clk;
  logic         rst = 1'b1;
  logic         s_tvalid = 1'b0;
  logic         s_tready;
  logic [143:0] s_tdata = '0;
  logic [1:0]   s_tuser = '0;
  logic         m_tvalid;
  logic         m_tready = 1'b0;
  logic [79:0]  m_tdata;

  entry_t       slot_shadow [SLOTS];
  reply_t       expected_replies [$];
  logic [53:0]  key_tags [4];
  int           send_idle_pct = 0;
  int           reply_stall_pct = 0;
  bit           hold_replies = 1'b0;
  int           fail_count = 0;
  int           cycle_count = 0;

  search_result_hash_table i_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Simulation FAILED");
    $finish;
  end

  // Slot update of one request; returns the reply the table should give.
  function automatic reply_t apply_table_op(req_t r);
    entry_t                    e;
    reply_t                    rep;
    logic [INDEX_BITS-1:0]     idx;
    logic signed [SCORE_W-1:0] sc;
    logic [BOUND_W-1:0]        bd;
    logic                      same;
    idx = r.key[INDEX_BITS-1:0];
    e = slot_shadow[idx];
    same = (e.key == r.key);
    sc = r.score;
    if (sc > SCORE_MAX) sc = SCORE_MAX;
    else if (sc < SCORE_MIN) sc = SCORE_MIN;
    bd = (r.bound == BOUND_BAD) ? BOUND_UPPER : r.bound;
    rep.written = 1'b0;
    case (r.kind)
      KIND_STORE_RESULT: begin
        if (!same || int'(e.depth) < int'(r.depth)) begin
          e.key = r.key;
          e.depth = $signed({1'b0, r.depth});
          e.score = sc;
          e.bound = bd;
          e.best_move = r.best_move;
          if (!same) begin
            e.eval = '0;
            e.eval_valid = 1'b0;
          end
          rep.written = 1'b1;
        end
      end
      KIND_STORE_EVAL: begin
        // empty slot takes key and eval but stays at depth -1
        if (e.depth < 0 || same) begin
          e.key = r.key;
          e.eval = r.pos_eval;
          e.eval_valid = 1'b1;
          rep.written = 1'b1;
        end
      end
      default: ;
    endcase
    slot_shadow[idx] = e;
    rep.found = same;
    rep.depth = e.depth;
    rep.score = e.score;
    rep.bound = e.bound;
    rep.best_move = e.best_move;
    rep.eval = e.eval;
    rep.eval_valid = e.eval_valid;
    return rep;
  endfunction

  function automatic req_t make_req(logic [KIND_W-1:0] kind, logic [KEY_W-1:0] key,
                                    int depth, int score, logic [BOUND_W-1:0] bound,
                                    logic [MOVE_W-1:0] best_move, int pos_eval);
    req_t r;
    r.kind = kind;
    r.key = key;
    r.depth = depth[DEPTH_W-1:0];
    r.score = score[SCORE_W-1:0];
    r.bound = bound;
    r.best_move = best_move;
    r.pos_eval = pos_eval[EVAL_W-1:0];
    return r;
  endfunction

  // Keys mostly from a small pool so slots collide and keys repeat.
  function automatic req_t random_request();
    req_t r;
    int   pick;
    pick = $urandom_range(0, 99);
    if (pick < 30) r.kind = KIND_PROBE;
    else if (pick < 75) r.kind = KIND_STORE_RESULT;
    else if (pick < 95) r.kind = KIND_STORE_EVAL;
    else r.kind = KIND_RESERVED;
    pick = $urandom_range(0, 99);
    if (pick < 70)
      r.key = {key_tags[$urandom_range(0, 3)], 10'($urandom_range(0, 31) * 33)};
    else if (pick < 75)
      r.key = '0;
    else
      r.key = {$urandom, $urandom};
    r.depth = DEPTH_W'($urandom_range(0, 127));
    if ($urandom_range(0, 99) < 70)
      r.score = SCORE_W'(int'($urandom_range(0, 20000000)) - 10000000);
    else
      r.score = SCORE_W'($urandom);
    r.bound = BOUND_W'($urandom_range(0, 3));
    r.best_move = MOVE_W'($urandom);
    r.pos_eval = EVAL_W'($urandom);
    return r;
  endfunction

  task automatic send_request(req_t r);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser <= r.kind;
    s_tdata <= {6'b0, r.pos_eval, r.best_move, r.bound, r.score, r.depth, r.key};
    do @(posedge clk); while (!s_tready);
    expected_replies.push_back(apply_table_op(r));
  endtask

  task automatic note_mismatch(string field, longint want, longint got);
    fail_count++;
    $display("%0t: %s mismatch, expected %0d, got %0d", $time, field, want, got);
  endtask

  // Reply side: random stalls, or one long hold when requested
  initial begin
    forever begin
      @(posedge clk);
      if (hold_replies) begin
        m_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_replies = 1'b0;
        m_tready <= 1'b1;
      end else begin
        m_tready <= ($urandom_range(0, 99) >= reply_stall_pct);
      end
    end
  end

  always @(posedge clk) begin : check_replies
    reply_t got;
    reply_t want;
    if (!rst && m_tvalid && m_tready) begin
      got.found = m_tdata[0];
      got.written = m_tdata[1];
      got.depth = m_tdata[9:2];
      got.score = m_tdata[34:10];
      got.bound = m_tdata[36:35];
      got.best_move = m_tdata[52:37];
      got.eval = m_tdata[76:53];
      got.eval_valid = m_tdata[77];
      if (expected_replies.size() == 0) begin
        fail_count++;
        $display("%0t: reply with none expected, data %h", $time, m_tdata);
      end else begin
        want = expected_replies.pop_front();
        if (got.found !== want.found) note_mismatch("found", want.found, got.found);
        if (got.written !== want.written)
          note_mismatch("written", want.written, got.written);
        if (got.depth !== want.depth) note_mismatch("found_depth", want.depth, got.depth);
        if (got.score !== want.score) note_mismatch("found_score", want.score, got.score);
        if (got.bound !== want.bound) note_mismatch("found_bound", want.bound, got.bound);
        if (got.best_move !== want.best_move)
          note_mismatch("found_move", want.best_move, got.best_move);
        if (got.eval !== want.eval) note_mismatch("found_eval", want.eval, got.eval);
        if (got.eval_valid !== want.eval_valid)
          note_mismatch("found_eval_valid", want.eval_valid, got.eval_valid);
      end
    end
  end

  task automatic test_directed_cases();
    logic [KEY_W-1:0] key_a;
    logic [KEY_W-1:0] key_b;
    logic [KEY_W-1:0] key_top;
    key_a = 64'h0123_4567_89AB_C005;
    key_b = 64'hFEDC_BA98_7654_3005;  // same slot as key_a
    key_top = '1;
    send_idle_pct = 20;
    reply_stall_pct = 20;
    // zero key hits a never-written slot, still reports empty
    send_request(make_req(KIND_PROBE, '0, 0, 0, BOUND_EXACT, '0, 0));
    send_request(make_req(KIND_PROBE, key_a, 0, 0, BOUND_EXACT, '0, 0));
    // eval into empty slot: depth stays -1
    send_request(make_req(KIND_STORE_EVAL, key_a, 0, 0, BOUND_EXACT, '0, 12345));
    // same key, deeper: eval kept
    send_request(make_req(KIND_STORE_RESULT, key_a, 5, 100, BOUND_LOWER, 16'h1234, 0));
    // same key, not deeper: unchanged
    send_request(make_req(KIND_STORE_RESULT, key_a, 5, -7, BOUND_UPPER, 16'h4321, 0));
    // largest raw score saturates, bad bound stored as upper
    send_request(make_req(KIND_STORE_RESULT, key_a, 127, 16777215, BOUND_BAD, 16'hFFFF, 0));
    send_request(make_req(KIND_PROBE, key_a, 0, 0, BOUND_EXACT, '0, 0));
    // new key on the slot: eval cleared, most negative score saturates
    send_request(make_req(KIND_STORE_RESULT, key_b, 0, -16777216, BOUND_EXACT, '0, 0));
    // eval for a foreign key on an occupied slot is dropped
    send_request(make_req(KIND_STORE_EVAL, key_a, 0, 0, BOUND_EXACT, '0, -5));
    send_request(make_req(KIND_STORE_EVAL, key_b, 0, 0, BOUND_EXACT, '0, 8388607));
    send_request(make_req(KIND_STORE_EVAL, key_b, 0, 0, BOUND_EXACT, '0, -8388608));
    // reserved kind acts as a probe
    send_request(make_req(KIND_RESERVED, key_b, 127, 5, BOUND_LOWER, 16'hAAAA, 77));
    send_request(make_req(KIND_STORE_RESULT, key_top, 0, 10000000, BOUND_UPPER, 16'h0001, 0));
    send_request(make_req(KIND_STORE_RESULT, key_top, 1, -10000000, BOUND_LOWER, 16'h8000, 0));
    send_request(make_req(KIND_STORE_RESULT, key_top, 2, 10000001, BOUND_EXACT, 16'h00FF, 0));
    send_request(make_req(KIND_STORE_RESULT, key_top, 3, -10000001, BOUND_BAD, 16'hFF00, 0));
    // zero key on the empty slot 0: same key, deeper than -1
    send_request(make_req(KIND_STORE_RESULT, '0, 0, 42, BOUND_LOWER, 16'h0042, 0));
    send_request(make_req(KIND_STORE_EVAL, '0, 0, 0, BOUND_EXACT, '0, -1));
    send_request(make_req(KIND_RESERVED, key_top, 64, -1, BOUND_BAD, 16'h5555, 4660));
  endtask

  task automatic test_random_mix();
    foreach (key_tags[i]) key_tags[i] = 54'({$urandom, $urandom});
    key_tags[0] = '0;
    send_idle_pct = 32;
    reply_stall_pct = 32;
    repeat (1000) send_request(random_request());
  endtask

  task automatic test_full_rate();
    send_idle_pct = 0;
    reply_stall_pct = 0;
    repeat (400) send_request(random_request());
  endtask

  task automatic test_reply_backpressure();
    send_idle_pct = 0;
    hold_replies = 1'b1;
    repeat (60) send_request(random_request());
    send_idle_pct = 32;
    reply_stall_pct = 32;
    repeat (340) send_request(random_request());
  endtask

  initial begin
    foreach (slot_shadow[i]) slot_shadow[i] = ENTRY_EMPTY;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    test_directed_cases();
    test_random_mix();
    test_full_rate();
    test_reply_backpressure();
    s_tvalid <= 1'b0;
    while (expected_replies.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (fail_count == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

endmodule
